FILE: src/hsl_pkg.sv
package hsl_pkg;

	// Fixed-point format: FRAC_BITS fraction bits, ONE means 1.0.
	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = 17;

	// Working width of a clamped value, signed working width, width of a
	// truncated product in the first stage, and stream data width.
	localparam int VW     = (FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W;
	localparam int SW     = VW + 4;
	localparam int PW     = 2 * VW + 1 - FRAC_BITS;
	localparam int DATA_W = ((3 * FIELD_W + 7) / 8) * 8;

	localparam longint ONE_I        = longint'(1) << FRAC_BITS;
	localparam longint THIRD_I      = (2 * ONE_I + 3) / 6;
	localparam longint SIXTH_I      = (2 * ONE_I + 6) / 12;
	localparam longint TWO_THIRDS_I = (4 * ONE_I + 3) / 6;
	localparam longint FIELD_MAX_I  = (longint'(1) << FIELD_W) - 1;

	typedef logic [FIELD_W-1:0] field_t;
	typedef logic [VW-1:0]      val_t;
	typedef logic signed [SW-1:0] sval_t;

	localparam val_t  ONE         = val_t'(ONE_I);
	localparam val_t  HALF        = val_t'(ONE_I / 2);
	localparam val_t  THIRD       = val_t'(THIRD_I);
	localparam val_t  SIXTH       = val_t'(SIXTH_I);
	localparam val_t  TWO_THIRDS  = val_t'(TWO_THIRDS_I);
	localparam sval_t ONE_S       = sval_t'(ONE_I);
	localparam sval_t FIELD_MAX_S = sval_t'(FIELD_MAX_I);

	// Hue ramp segment
	typedef enum logic [1:0] {
		SEG_RISE = 2'd0,
		SEG_HIGH = 2'd1,
		SEG_FALL = 2'd2,
		SEG_LOW  = 2'd3
	} seg_t;

	typedef struct packed {
		seg_t seg;
		val_t fac;   // ramp distance, zero on flat segments
	} lane_t;

	typedef struct packed {
		logic              zero;
		logic              lo;
		val_t              l;
		val_t              s;
		logic [PW-1:0]     prodf;
		lane_t [2:0]       lane;   // red, green, blue from index 0
	} s1_t;

	typedef struct packed {
		logic        zero;
		val_t        l;
		sval_t       p;
		sval_t       q;
		sval_t       d6;
		lane_t [2:0] lane;
	} s2_t;

	function automatic val_t clamp_in(input field_t raw);
		val_t v;
		v = val_t'(raw);
		return (v > ONE) ? ONE : v;
	endfunction

	function automatic lane_t classify(input val_t t);
		lane_t r;
		r.fac = '0;
		if (t < SIXTH) begin
			r.seg = SEG_RISE;
			r.fac = t;
		end else if (t < HALF) begin
			r.seg = SEG_HIGH;
		end else if (t < TWO_THIRDS) begin
			r.seg = SEG_FALL;
			r.fac = TWO_THIRDS - t;
		end else begin
			r.seg = SEG_LOW;
		end
		return r;
	endfunction

	function automatic field_t sat_out(input sval_t v);
		sval_t c;
		if (v < 0)
			c = '0;
		else if (v > ONE_S)
			c = ONE_S;
		else
			c = v;
		if (c > FIELD_MAX_S)
			c = FIELD_MAX_S;
		return c[FIELD_W-1:0];
	endfunction

endpackage

FILE: src/hsl_prep.sv
module hsl_prep import hsl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  field_t hue,
	input  field_t saturation,
	input  field_t lightness,
	output logic   out_valid,
	input  logic   out_ready,
	output s1_t    out_data
);

	val_t          h, s, l;
	logic          lo;
	logic [VW:0]   mb;
	logic [2*VW:0] prod;
	logic [VW:0]   t_r_sum;
	val_t          t_r, t_b;
	s1_t           nxt;
	logic          valid_s1;
	s1_t           data_s1;

	always_comb begin
		h  = clamp_in(hue);
		s  = clamp_in(saturation);
		l  = clamp_in(lightness);
		lo = (l < HALF);
		// l*(1+s) below half, l*s otherwise
		mb   = lo ? ({1'b0, ONE} + {1'b0, s}) : {1'b0, s};
		prod = (2*VW+1)'(l) * (2*VW+1)'(mb);

		// hue offsets, wrapped once into [0, ONE]
		t_r_sum = {1'b0, h} + {1'b0, THIRD};
		t_r = (t_r_sum > {1'b0, ONE}) ? val_t'(t_r_sum - {1'b0, ONE}) : val_t'(t_r_sum);
		t_b = (h < THIRD) ? val_t'(h + ONE - THIRD) : val_t'(h - THIRD);

		nxt.zero    = (s == '0);
		nxt.lo      = lo;
		nxt.l       = l;
		nxt.s       = s;
		nxt.prodf   = prod[2*VW:FRAC_BITS];
		nxt.lane[0] = classify(t_r);
		nxt.lane[1] = classify(h);
		nxt.lane[2] = classify(t_b);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

FILE: src/hsl_mix.sv
module hsl_mix import hsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  s1_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output s2_t  out_data
);

	sval_t l_x, s_x, pf_x, q, p, d;
	s2_t   nxt;
	logic  valid_s2;
	s2_t   data_s2;

	always_comb begin
		l_x  = sval_t'(in_data.l);
		s_x  = sval_t'(in_data.s);
		pf_x = sval_t'(in_data.prodf);
		q    = in_data.lo ? pf_x : (l_x + s_x - pf_x);
		p    = (l_x <<< 1) - q;
		d    = q - p;
		if (d < 0)
			d = '0;

		nxt.zero = in_data.zero;
		nxt.l    = in_data.l;
		nxt.p    = p;
		nxt.q    = q;
		nxt.d6   = (d <<< 2) + (d <<< 1);
		nxt.lane = in_data.lane;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= nxt;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

FILE: src/hsl_ramp.sv
module hsl_ramp import hsl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  s2_t    in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output field_t red,
	output field_t green,
	output field_t blue
);

	logic [SW+VW-1:0] m [3];
	sval_t [2:0]      mf_nxt;
	field_t [2:0]     ch_nxt;
	sval_t            v;
	logic             ready_s3, ready_s4;

	logic         valid_s3;
	logic         zero_s3;
	val_t         l_s3;
	sval_t        p_s3, q_s3;
	seg_t [2:0]   seg_s3;
	sval_t [2:0]  mf_s3;

	logic         valid_s4;
	field_t [2:0] ch_s4;

	// one multiplier per lane: slope times distance into the ramp
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m[i]      = (SW+VW)'($unsigned(in_data.d6)) * (SW+VW)'(in_data.lane[i].fac);
			mf_nxt[i] = sval_t'(m[i] >> FRAC_BITS);
		end
	end

	always_comb begin
		v = '0;
		for (int i = 0; i < 3; i++) begin
			case (seg_s3[i])
				SEG_RISE, SEG_FALL: v = p_s3 + mf_s3[i];
				SEG_HIGH:           v = q_s3;
				SEG_LOW:            v = p_s3;
				default:            v = p_s3;
			endcase
			ch_nxt[i] = zero_s3 ? sat_out(sval_t'(l_s3)) : sat_out(v);
		end
	end

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3)
				valid_s3 <= in_valid;
			if (ready_s4)
				valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s3) begin
			zero_s3 <= in_data.zero;
			l_s3    <= in_data.l;
			p_s3    <= in_data.p;
			q_s3    <= in_data.q;
			for (int i = 0; i < 3; i++) begin
				seg_s3[i] <= in_data.lane[i].seg;
			end
			mf_s3   <= mf_nxt;
		end
		if (valid_s3 && ready_s4) begin
			ch_s4 <= ch_nxt;
		end
	end

	assign out_valid = valid_s4;
	assign red       = ch_s4[0];
	assign green     = ch_s4[1];
	assign blue      = ch_s4[2];

endmodule

FILE: src/hsl_to_rgb_converter.sv
// HSL to RGB color converter.
// Input stream s_axis: one beat carries one color as hue, saturation and
// lightness, each an unsigned 17-bit fraction with 16 fraction bits
// (65536 = 1.0; larger codes are clamped to 1.0 on entry).
// Output stream m_axis: one beat per input beat, in order, carrying red,
// green and blue in the same format, saturated to [0, 1.0].
// Pipeline: four register stages -- clamp, hue offsets and the product
// l*(1+s) or l*s; q/p/slope; the per-channel slope multiplies; segment
// select and saturation into the output register.
// An input beat accepted on s_axis passes the stage 1, 2, 3 and 4
// registers in order and is then offered on m_axis.
// Throughput: one beat per clock while m_tready is high; each stage holds
// a valid bit and loads whenever it is empty or the stage after it moves.
// Stall: when m_tready is low the output holds its beat; upstream stages
// keep filling their bubbles, so s_axis_tready only drops once all four
// stages are full. Nothing is dropped or repeated.
// Reset (arst_n low, asynchronous): all valid bits clear; the pipeline is
// empty and ready right after reset.
module hsl_to_rgb_converter import hsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // hue, saturation, lightness, zero pad
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata   // red, green, blue, zero pad
);

	field_t hue, saturation, lightness;
	field_t red, green, blue;

	logic s1_valid, s1_ready;
	s1_t  s1_data;
	logic s2_valid, s2_ready;
	s2_t  s2_data;

	// unpack input beat
	assign hue        = s_axis_tdata[FIELD_W-1:0];
	assign saturation = s_axis_tdata[2*FIELD_W-1:FIELD_W];
	assign lightness  = s_axis_tdata[3*FIELD_W-1:2*FIELD_W];

	// stage 1: clamp, q product, wrapped hue offsets, ramp segments
	hsl_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.out_valid  (s1_valid),
		.out_ready  (s1_ready),
		.out_data   (s1_data)
	);

	// stage 2: q, p and six times the ramp height
	hsl_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_ready  (s1_ready),
		.in_data   (s1_data),
		.out_valid (s2_valid),
		.out_ready (s2_ready),
		.out_data  (s2_data)
	);

	// stages 3 and 4: per-channel multiply, then select and saturate
	hsl_ramp u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s2_valid),
		.in_ready  (s2_ready),
		.in_data   (s2_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// pack output beat
	assign m_axis_tdata = {{(DATA_W - 3 * FIELD_W){1'b0}}, blue, green, red};

endmodule

FILE: bench/hsl_rgb_checker.sv
`timescale 1ns / 1ps

// Watches both stream ports of the HSL to RGB converter, predicts each output
// beat from the input beat and compares field by field, in order.
module hsl_rgb_checker import hsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [DATA_W-1:0] in_data,   // hue, saturation, lightness, zero pad
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [DATA_W-1:0] out_data,  // red, green, blue, zero pad
	output int                fail_count,
	output int                pending,
	output int                rgb_checked,
	output int                gray_count
);

	typedef struct {
		field_t red;
		field_t green;
		field_t blue;
	} rgb_t;

	rgb_t rgb_expected[$];

	function automatic longint unit_clamp(input field_t raw);
		longint v;
		v = longint'(raw);
		return (v > ONE_I) ? ONE_I : v;
	endfunction

	// exact product, truncated back to FRAC_BITS fraction bits
	function automatic longint frac_mul(input longint a, input longint b);
		if (a < 0)
			a = 0;
		if (b < 0)
			b = 0;
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic field_t to_field(input longint v);
		if (v < 0)
			v = 0;
		if (v > ONE_I)
			v = ONE_I;
		if (v > FIELD_MAX_I)
			v = FIELD_MAX_I;
		return field_t'(v);
	endfunction

	function automatic longint hue_channel(input longint p, input longint q, input longint t);
		longint d;
		d = q - p;
		if (d < 0)
			d = 0;
		if (t < 0)
			t = t + ONE_I;
		if (t > ONE_I)
			t = t - ONE_I;
		if (t < SIXTH_I)
			return p + frac_mul(d * 6, t);
		if (t < ONE_I / 2)
			return q;
		if (t < TWO_THIRDS_I)
			return p + frac_mul(d * 6, TWO_THIRDS_I - t);
		return p;
	endfunction

	function automatic rgb_t hsl_to_rgb_predict(input field_t h_raw, input field_t s_raw,
			input field_t l_raw);
		longint h, s, l, p, q;
		rgb_t r;
		h = unit_clamp(h_raw);
		s = unit_clamp(s_raw);
		l = unit_clamp(l_raw);
		if (s == 0) begin
			r.red   = to_field(l);
			r.green = to_field(l);
			r.blue  = to_field(l);
			return r;
		end
		if (l < ONE_I / 2)
			q = frac_mul(l, ONE_I + s);
		else
			q = l + s - frac_mul(l, s);
		p = 2 * l - q;
		r.red   = to_field(hue_channel(p, q, h + THIRD_I));
		r.green = to_field(hue_channel(p, q, h));
		r.blue  = to_field(hue_channel(p, q, h - THIRD_I));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t exp_rgb;
		field_t got_r, got_g, got_b;
		logic [DATA_W-3*FIELD_W-1:0] got_pad;
		if (!arst_n) begin
			rgb_expected.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_r   = out_data[FIELD_W-1:0];
				got_g   = out_data[2*FIELD_W-1:FIELD_W];
				got_b   = out_data[3*FIELD_W-1:2*FIELD_W];
				got_pad = out_data[DATA_W-1:3*FIELD_W];
				if (rgb_expected.size() == 0) begin
					$error("output beat with nothing expected: rgb %0d %0d %0d",
						got_r, got_g, got_b);
					fail_count++;
				end else begin
					exp_rgb = rgb_expected.pop_front();
					rgb_checked++;
					if (got_r !== exp_rgb.red) begin
						$error("red mismatch: expected %0d actual %0d", exp_rgb.red, got_r);
						fail_count++;
					end
					if (got_g !== exp_rgb.green) begin
						$error("green mismatch: expected %0d actual %0d", exp_rgb.green,
							got_g);
						fail_count++;
					end
					if (got_b !== exp_rgb.blue) begin
						$error("blue mismatch: expected %0d actual %0d", exp_rgb.blue, got_b);
						fail_count++;
					end
					if (got_pad !== '0) begin
						$error("pad mismatch: expected 0 actual %0h", got_pad);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				rgb_expected.push_back(hsl_to_rgb_predict(in_data[FIELD_W-1:0],
					in_data[2*FIELD_W-1:FIELD_W], in_data[3*FIELD_W-1:2*FIELD_W]));
				if (in_data[2*FIELD_W-1:FIELD_W] == '0)
					gray_count++;
			end
			pending = rgb_expected.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the HSL to RGB converter. All prediction and
// comparison lives in hsl_rgb_checker; this module only drives beats, paces
// the output side and reports.
module tb_top;
	import hsl_pkg::*;

	localparam int     N_PHASES    = 8;
	localparam int     PHASE_BEATS = 200;
	localparam int     HOLD_CYCLES = 300;     // long output stall, fills the pipe
	localparam int     DRAIN_TAIL  = 12;      // slack after the drain for a stray beat
	localparam longint TIMEOUT_NS  = 8000000; // several times the worst run

	localparam field_t F_ONE   = field_t'(ONE_I);
	localparam field_t F_HALF  = field_t'(ONE_I / 2);
	localparam field_t F_THIRD = field_t'(THIRD_I);
	localparam field_t F_SIXTH = field_t'(SIXTH_I);
	localparam field_t F_TWO3  = field_t'(TWO_THIRDS_I);
	localparam field_t F_MAX   = field_t'(FIELD_MAX_I);
	localparam field_t F_LSB   = field_t'(1);

	localparam int U_ONE = int'(ONE_I);
	localparam int U_MAX = int'(FIELD_MAX_I);

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;

	int fail_count;
	int pending;
	int rgb_checked;
	int gray_count;

	int beats_sent = 0;
	int over_one   = 0;      // beats with at least one field above 1.0

	// pacing modes, set per phase by the stimulus process
	bit tx_steady = 1'b0;    // sender offers back to back
	bit rx_steady = 1'b0;    // receiver ready unless a stall is running
	bit hold_req  = 1'b0;    // toggled to ask the receiver for one long stall

	hsl_to_rgb_converter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	hsl_rgb_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_data     (s_axis_tdata),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.fail_count  (fail_count),
		.pending     (pending),
		.rgb_checked (rgb_checked),
		.gray_count  (gray_count)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Idle length: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Field value: mostly in [0, 1.0], with the edges and the clamp region
	// (codes above 1.0) hit often enough that every bit toggles.
	function automatic field_t rand_field();
		case ($urandom_range(0, 11))
			0:       return F_ONE;
			1:       return '0;
			2:       return field_t'($urandom_range(0, U_MAX));
			3:       return field_t'($urandom_range(0, 15));
			4:       return field_t'($urandom_range(U_ONE / 2 - 8, U_ONE / 2 + 8));
			5:       return field_t'($urandom_range(U_ONE - 16, U_ONE));
			default: return field_t'($urandom_range(0, U_ONE));
		endcase
	endfunction

	// One input beat. Gaps go in front of the beat; valid stays high across
	// back-to-back beats so each negedge makes a single assignment.
	task automatic send_hsl(input field_t h, input field_t s, input field_t l);
		int gap;
		gap = tx_steady ? 0 : idle_len();
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(DATA_W - 3 * FIELD_W){1'b0}}, l, s, h};
		do
			@(posedge clk);
		while (!s_axis_tready);
		beats_sent++;
		if (h > F_ONE || s > F_ONE || l > F_ONE)
			over_one++;
	endtask

	// Output side pacing. Random stalls, steady stretches, and on request one
	// long stall counted here while the sender keeps pushing.
	initial begin
		int stall_left;
		int g;
		bit hold_seen;
		stall_left    = 0;
		hold_seen     = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen  = hold_req;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				g = idle_len();
				if (g > 0) begin
					stall_left = g - 1;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats: field extremes, gray path, clamp of codes above 1.0,
		// lightness on both sides of one half, segment edges of the ramp, and
		// the wrap of the red and blue offsets.
		send_hsl('0, '0, '0);
		send_hsl(F_ONE, F_ONE, F_ONE);
		send_hsl(F_MAX, F_MAX, F_MAX);                // everything clamps to 1.0
		send_hsl(field_t'(12345), '0, F_HALF);       // zero saturation, gray
		send_hsl(F_MAX, '0, F_MAX);                  // gray, lightness clamped
		send_hsl(F_ONE, F_ONE, F_HALF);              // hue exactly one
		send_hsl('0, F_ONE, F_HALF);
		send_hsl(field_t'(1), field_t'(1), field_t'(1));
		send_hsl(field_t'(9000), F_ONE, F_HALF - F_LSB); // l just below one half
		send_hsl(field_t'(9000), F_ONE, F_HALF);     // l at one half
		send_hsl(F_SIXTH - F_LSB, F_ONE, F_HALF);
		send_hsl(F_SIXTH, F_ONE, F_HALF);
		send_hsl(F_HALF - F_LSB, F_ONE, F_HALF);
		send_hsl(F_HALF, F_ONE, F_HALF);
		send_hsl(F_TWO3 - F_LSB, F_ONE, F_HALF);
		send_hsl(F_TWO3, F_ONE, F_HALF);
		send_hsl(F_THIRD - F_LSB, field_t'(40000), field_t'(20000)); // blue wraps up
		send_hsl(F_THIRD, field_t'(40000), field_t'(20000));
		send_hsl(F_ONE - F_THIRD, field_t'(50000), field_t'(45000)); // red at t = 1.0
		send_hsl(F_ONE - F_THIRD + F_LSB, field_t'(50000), field_t'(45000)); // red wraps down
		send_hsl(field_t'(30000), F_ONE + F_LSB, F_ONE + F_LSB); // just above one
		send_hsl(field_t'(20000), field_t'(1), F_ONE - F_LSB);

		// Random phases, with the pacing mix set per phase.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			tx_steady = (ph == 1 || ph == 3 || ph == 6);
			rx_steady = (ph == 2 || ph == 3 || ph == 5);
			if (ph == 3 || ph == 6)
				hold_req = !hold_req;  // back-pressure all the way to s_axis
			for (int i = 0; i < PHASE_BEATS; i++)
				send_hsl(rand_field(), rand_field(), rand_field());
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		rx_steady = 1'b1;

		// drain, then a few more clocks to catch any stray beat
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		$display("Sent %0d beats (%0d gray, %0d with codes above 1.0), checked %0d results.",
			beats_sent, gray_count, over_one, rgb_checked);
		$display("Pacing covered random gaps, steady streams and long output stalls.");
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/hsl_pkg.sv
src/hsl_prep.sv
src/hsl_mix.sv
src/hsl_ramp.sv
src/hsl_to_rgb_converter.sv
bench/hsl_rgb_checker.sv
bench/tb_top.sv
